@@ rtl/core/time_histogram_range_counter_macros.svh @@
// Assertion macros for the time histogram range counter checker.
`ifndef TIME_HISTOGRAM_RANGE_COUNTER_MACROS_SVH
`define TIME_HISTOGRAM_RANGE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: property violated");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: property violated");

`endif

@@ rtl/core/thrc_pkg.sv @@
// Shared types, codes and helpers of the time histogram range counter.
package thrc_pkg;

  localparam int unsigned MODE_W      = 3;
  localparam int unsigned TIME_W      = 17;
  localparam int unsigned OUT_CNT_W   = 20;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = MODE_W;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam logic [OUT_CNT_W-1:0] OUT_MAX = '1;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_WRONG_PHASE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_BUILD  = 3'd1,
    MODE_TOTAL  = 3'd2,
    MODE_PERIOD = 3'd3,
    MODE_SLOT   = 3'd4
  } mode_e;

  // Slot store control: read, clear write, saturating increment write.
  typedef struct packed {
    logic rd;
    logic clr;
    logic inc;
  } slot_ctl_t;

  // Prefix store control: read, capture upper bound, start and step the build.
  typedef struct packed {
    logic rd;
    logic hold;
    logic acc_clr;
    logic acc_en;
  } prf_ctl_t;

  function automatic logic [OUT_CNT_W-1:0] sat_out(logic [31:0] v);
    logic [OUT_CNT_W-1:0] r;
    if (v > 32'(OUT_MAX)) begin
      r = OUT_MAX;
    end else begin
      r = v[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/time_histogram_range_counter.sv @@
// Reset runs a clearing pass over the slot memory; tready stays low meanwhile.
// Add: the slot is read, then written back incremented; no new item is taken before the write.
// Total query and rejected items: the result passes the result register, then the output register.
// Slot query: one read of the slot memory; period query: two reads of the prefix memory.
// Build: one slot per cycle through the prefix accumulator.
// One item at a time; a result waiting in S_EMIT for the output register blocks the next input transfer.
module time_histogram_range_counter #(
  parameter int unsigned NUM_SLOTS  = 86400,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [16:0] time_a, [33:17] time_b, [39:34] zero
  input  logic [thrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] mode
  input  logic [thrc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [19:0] count, [23:20] zero
  output logic [thrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] status
  output logic [thrc_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);
  import thrc_pkg::*;

  localparam int unsigned SA_W = $clog2(NUM_SLOTS);
  localparam int unsigned PA_W = $clog2(NUM_SLOTS + 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_ADD_WR  = 8'b0000_0100,
    S_SLOT_RD = 8'b0000_1000,
    S_BUILD   = 8'b0001_0000,
    S_PER_RD0 = 8'b0010_0000,
    S_PER_RD1 = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [PA_W-1:0]       cnt_q, cnt_d;
  logic [TIME_W-1:0]     addr_q, addr_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  built_q, built_d;
  logic [OUT_CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic                  res_sts_q, res_sts_d;
  logic                  out_valid_q;
  logic [OUT_CNT_W-1:0]  out_cnt_q;
  logic                  out_sts_q;
  logic                  out_load;

  mode_e                 mode;
  logic [TIME_W-1:0]     time_a;
  logic [TIME_W-1:0]     time_b;
  logic [TIME_W-1:0]     tb_clamp;
  logic                  ta_ok;
  logic                  in_xfer;

  slot_ctl_t             slot_ctl;
  logic [SA_W-1:0]       slot_rd_addr;
  logic [SA_W-1:0]       slot_wr_addr;
  logic [COUNT_BITS-1:0] slot_rd_data;
  prf_ctl_t              prf_ctl;
  logic [PA_W-1:0]       prf_rd_addr;
  logic [PA_W-1:0]       prf_wr_addr;
  logic [COUNT_BITS-1:0] prf_diff;

  assign mode     = mode_e'(s_axis_tuser_i);
  assign time_a   = s_axis_tdata_i[TIME_W-1:0];
  assign time_b   = s_axis_tdata_i[2*TIME_W-1:TIME_W];
  assign ta_ok    = 32'(time_a) < NUM_SLOTS;
  assign tb_clamp = (32'(time_b) >= NUM_SLOTS) ? TIME_W'(NUM_SLOTS - 1) : time_b;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    total_d      = total_q;
    built_d      = built_q;
    res_cnt_d    = res_cnt_q;
    res_sts_d    = res_sts_q;
    out_load     = 1'b0;
    slot_ctl     = '0;
    prf_ctl      = '0;
    slot_rd_addr = time_a[SA_W-1:0];
    slot_wr_addr = addr_q[SA_W-1:0];
    prf_rd_addr  = PA_W'(tb_clamp) + 1'b1;
    prf_wr_addr  = cnt_q;

    case (state_q)
      S_CLEAR: begin
        slot_ctl.clr = 1'b1;
        slot_wr_addr = cnt_q[SA_W-1:0];
        if (cnt_q == PA_W'(NUM_SLOTS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          addr_d = time_a;
          case (mode)
            MODE_ADD: begin
              if (built_q) begin
                res_cnt_d = '0;
                res_sts_d = STATUS_WRONG_PHASE;
                state_d   = S_EMIT;
              end else if (ta_ok) begin
                slot_ctl.rd = 1'b1;
                total_d     = (total_q == CntMax) ? total_q : total_q + 1'b1;
                state_d     = S_ADD_WR;
              end
            end
            MODE_BUILD: begin
              cnt_d   = '0;
              state_d = S_BUILD;
            end
            MODE_TOTAL: begin
              res_cnt_d = sat_out(32'(total_q));
              res_sts_d = STATUS_OK;
              state_d   = S_EMIT;
            end
            MODE_PERIOD: begin
              if (!built_q) begin
                res_cnt_d = '0;
                res_sts_d = STATUS_WRONG_PHASE;
                state_d   = S_EMIT;
              end else if (time_a > tb_clamp) begin
                res_cnt_d = '0;
                res_sts_d = STATUS_OK;
                state_d   = S_EMIT;
              end else begin
                // Read the upper bound first, the lower bound next cycle.
                prf_ctl.rd = 1'b1;
                state_d    = S_PER_RD0;
              end
            end
            MODE_SLOT: begin
              if (ta_ok) begin
                slot_ctl.rd = 1'b1;
                state_d     = S_SLOT_RD;
              end else begin
                res_cnt_d = '0;
                res_sts_d = STATUS_OK;
                state_d   = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_ADD_WR: begin
        slot_ctl.inc = 1'b1;
        state_d      = S_IDLE;
      end

      S_SLOT_RD: begin
        res_cnt_d = sat_out(32'(slot_rd_data));
        res_sts_d = STATUS_OK;
        state_d   = S_EMIT;
      end

      // Issue the slot read at cnt_q; data of slot cnt_q-1 lands at prefix entry cnt_q.
      S_BUILD: begin
        slot_rd_addr    = cnt_q[SA_W-1:0];
        slot_ctl.rd     = (cnt_q != PA_W'(NUM_SLOTS));
        prf_ctl.acc_clr = (cnt_q == '0);
        prf_ctl.acc_en  = (cnt_q != '0);
        if (cnt_q == PA_W'(NUM_SLOTS)) begin
          built_d = 1'b1;
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_PER_RD0: begin
        prf_ctl.hold = 1'b1;
        prf_ctl.rd   = 1'b1;
        prf_rd_addr  = PA_W'(addr_q);
        state_d      = S_PER_RD1;
      end

      S_PER_RD1: begin
        res_cnt_d = sat_out(32'(prf_diff));
        res_sts_d = STATUS_OK;
        state_d   = S_EMIT;
      end

      // Hold the result until the output register is free.
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      total_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      built_q <= built_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    res_cnt_q <= res_cnt_d;
    res_sts_q <= res_sts_d;
    if (out_load) begin
      out_cnt_q <= res_cnt_q;
      out_sts_q <= res_sts_q;
    end
  end

  thrc_slot_store #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (SA_W)
  ) u_slot_store (
    .clk_i     (clk_i),
    .ctl_i     (slot_ctl),
    .rd_addr_i (slot_rd_addr),
    .wr_addr_i (slot_wr_addr),
    .rd_data_o (slot_rd_data)
  );

  thrc_prefix_store #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (PA_W)
  ) u_prefix_store (
    .clk_i       (clk_i),
    .ctl_i       (prf_ctl),
    .rd_addr_i   (prf_rd_addr),
    .wr_addr_i   (prf_wr_addr),
    .slot_data_i (slot_rd_data),
    .diff_o      (prf_diff)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_cnt_q);
  assign m_axis_tuser_o  = out_sts_q;

endmodule

@@ rtl/core/thrc_slot_store.sv @@
// Per-second event count memory with clear and saturating increment writes.
module thrc_slot_store #(
  parameter int unsigned NUM_SLOTS  = 86400,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned ADDR_W     = $clog2(NUM_SLOTS)
) (
  input  logic                  clk_i,
  input  thrc_pkg::slot_ctl_t   ctl_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o
);
  import thrc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] mem_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  wr_en;

  assign wr_en = ctl_i.clr | ctl_i.inc;

  // Increment uses the value read in the previous cycle; hold at full scale.
  always_comb begin
    wr_data = '0;
    if (ctl_i.inc) begin
      wr_data = (rd_data_q == CntMax) ? rd_data_q : rd_data_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/thrc_prefix_store.sv @@
// Exclusive prefix sum memory with build accumulator and range difference.
module thrc_prefix_store #(
  parameter int unsigned NUM_SLOTS  = 86400,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned ADDR_W     = $clog2(NUM_SLOTS + 1)
) (
  input  logic                  clk_i,
  input  thrc_pkg::prf_ctl_t    ctl_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  logic [COUNT_BITS-1:0] slot_data_i,
  output logic [COUNT_BITS-1:0] diff_o
);
  import thrc_pkg::*;

  localparam int unsigned Depth = NUM_SLOTS + 1;

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic [COUNT_BITS-1:0] hi_q;
  logic [COUNT_BITS-1:0] acc_q;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] acc_new;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  wr_en;

  // Saturate on carry out: both operands never exceed full scale.
  assign sum     = {1'b0, acc_q} + {1'b0, slot_data_i};
  assign acc_new = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign wr_en   = ctl_i.acc_clr | ctl_i.acc_en;
  assign wr_data = ctl_i.acc_clr ? '0 : acc_new;

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (ctl_i.hold) begin
      hi_q <= rd_data_q;
    end
  end

  // Sums are non-decreasing, so the window count never goes negative.
  assign diff_o = hi_q - rd_data_q;

endmodule

@@ rtl/core/thrc_checker.sv @@
// Port-level checks of the time histogram range counter and their bind.
`include "time_histogram_range_counter_macros.svh"

module thrc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [thrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [thrc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [thrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [thrc_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);
  import thrc_pkg::*;

  logic                               in_xfer;
  logic                               busy_mode;
  logic                               out_stall;
  logic [OUT_TDATA_W+OUT_TUSER_W-1:0] out_word;

  assign in_xfer   = s_axis_tvalid_i & s_axis_tready_o;
  assign busy_mode = s_axis_tuser_i inside {MODE_BUILD, MODE_TOTAL, MODE_PERIOD, MODE_SLOT};
  assign out_stall = m_axis_tvalid_o & ~m_axis_tready_i;
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};

  // A rejected transfer always carries a zero count and zero padding.
  `THRC_ASSERT_IMP(a_reject_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0)

  // A stalled result holds its payload.
  `THRC_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_word))

  // Build and query items occupy the block: tready is low right after their transfer.
  `THRC_ASSERT_NXT(a_busy_after_query, in_xfer && busy_mode, !s_axis_tready_o)

endmodule

bind time_histogram_range_counter thrc_checker u_thrc_checker (.*);

@@ tb/tb_time_histogram_range_counter.sv @@
// Self-checking testbench for the time histogram range counter: directed and random stream traffic.
module tb_time_histogram_range_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import thrc_pkg::*;

  localparam int unsigned NUM_SLOTS  = 86400;
  localparam int unsigned COUNT_BITS = 20;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int unsigned TIME_MAX   = (1 << TIME_W) - 1;

  typedef struct {
    logic [OUT_CNT_W-1:0] count;
    logic                 status;
  } answer_t;

  // Scoreboard: mirrors the histogram and holds the answers still due.
  class hist_scoreboard;
    logic [COUNT_BITS-1:0] slot_cnt [NUM_SLOTS];
    logic [COUNT_BITS-1:0] prefix [NUM_SLOTS+1];
    logic [COUNT_BITS-1:0] total;
    bit                    built;
    answer_t               answers_due [$];
    int unsigned           errors;

    function new();
      foreach (slot_cnt[i]) slot_cnt[i] = '0;
      foreach (prefix[i]) prefix[i] = '0;
      total  = '0;
      built  = 1'b0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function logic [OUT_CNT_W-1:0] clamp_out(longint unsigned v);
      longint unsigned lim;
      lim = (64'd1 << OUT_CNT_W) - 64'd1;
      return (v > lim) ? lim[OUT_CNT_W-1:0] : v[OUT_CNT_W-1:0];
    endfunction

    function void push_answer(longint unsigned cnt, logic status);
      answer_t a;
      a.count  = clamp_out(cnt);
      a.status = status;
      answers_due.push_back(a);
    endfunction

    // Predict the effect of one accepted input transfer.
    function void note_item(logic [MODE_W-1:0] md, logic [TIME_W-1:0] ta,
                            logic [TIME_W-1:0] tb);
      longint unsigned acc;
      longint unsigned hi;
      case (mode_e'(md))
        MODE_ADD: begin
          if (built) begin
            push_answer(0, STATUS_WRONG_PHASE);
          end else if (ta < NUM_SLOTS) begin
            if (slot_cnt[ta] < CNT_MAX) slot_cnt[ta] = slot_cnt[ta] + 1'b1;
            if (total < CNT_MAX) total = total + 1'b1;
          end
        end
        MODE_BUILD: begin
          acc = 0;
          prefix[0] = '0;
          for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
            acc += slot_cnt[i];
            if (acc > CNT_MAX) acc = CNT_MAX;
            prefix[i+1] = acc[COUNT_BITS-1:0];
          end
          built = 1'b1;
        end
        MODE_TOTAL: push_answer(total, STATUS_OK);
        MODE_PERIOD: begin
          hi = (tb >= NUM_SLOTS) ? NUM_SLOTS - 1 : tb;
          if (!built) begin
            push_answer(0, STATUS_WRONG_PHASE);
          end else if (ta > hi) begin
            push_answer(0, STATUS_OK);
          end else begin
            push_answer(longint'(prefix[hi+1]) - longint'(prefix[ta]), STATUS_OK);
          end
        end
        MODE_SLOT: begin
          if (ta >= NUM_SLOTS) push_answer(0, STATUS_OK);
          else push_answer(slot_cnt[ta], STATUS_OK);
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [OUT_CNT_W-1:0] count, logic status);
      answer_t a;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d status=%0d", count, status));
      end else begin
        a = answers_due.pop_front();
        if (count !== a.count) begin
          report_mismatch($sformatf("count %0d, expected %0d", count, a.count));
        end
        if (status !== a.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, a.status));
        end
      end
    endtask
  endclass

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;  // [16:0] time_a, [33:17] time_b, [39:34] zero
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;  // [2:0] mode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [19:0] count, [23:20] zero
  logic [OUT_TUSER_W-1:0] m_tuser;        // [0] status

  hist_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned rx_cycle   = 0;
  int unsigned rx_style   = 0;
  int unsigned hot_slot [8];

  time_histogram_range_counter #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: switch between always ready, half stalled and mostly stalled.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 48 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0, 1: m_tready <= 1'b1;
      2: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      sb.note_item(s_tuser, s_tdata[16:0], s_tdata[33:17]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check_result(m_tdata[OUT_CNT_W-1:0], m_tuser[0]);
    end
  end

  // Present one item and hold it until its transfer; drop valid at the end of a burst.
  task automatic send_item(input logic [MODE_W-1:0] md, input int unsigned ta,
                           input int unsigned tb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {6'b0, tb[TIME_W-1:0], ta[TIME_W-1:0]};
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic stop_sending();
    if (burst_left != 0) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
    end
  endtask

  function automatic int unsigned near_hot();
    int v;
    v = int'(hot_slot[$urandom_range(0, 7)]) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > int'(NUM_SLOTS) - 1) v = NUM_SLOTS - 1;
    return v;
  endfunction

  task automatic run_collect_random(input int unsigned n);
    int unsigned r;
    int unsigned ta;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: ta = hot_slot[$urandom_range(0, 7)];
          10, 11, 12: ta = near_hot();
          13: ta = $urandom_range(NUM_SLOTS, TIME_MAX);
          default: ta = $urandom_range(0, NUM_SLOTS - 1);
        endcase
        send_item(MODE_ADD, ta, $urandom_range(0, TIME_MAX));
      end else if (r < 80) begin
        ta = ($urandom_range(0, 1) == 1) ? near_hot() : $urandom_range(0, TIME_MAX);
        send_item(MODE_SLOT, ta, $urandom_range(0, TIME_MAX));
      end else if (r < 88) begin
        send_item(MODE_TOTAL, $urandom_range(0, TIME_MAX), $urandom_range(0, TIME_MAX));
      end else if (r < 95) begin
        send_item(MODE_PERIOD, $urandom_range(0, TIME_MAX), $urandom_range(0, TIME_MAX));
      end else begin
        send_item(MODE_W'($urandom_range(5, 7)), $urandom_range(0, TIME_MAX),
                  $urandom_range(0, TIME_MAX));
      end
    end
  endtask

  task automatic run_query_random(input int unsigned n);
    int unsigned r;
    int unsigned ta;
    int unsigned tb;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 9))
          0: begin
            ta = $urandom_range(0, TIME_MAX);
            tb = $urandom_range(0, TIME_MAX);
          end
          1: begin
            ta = near_hot();
            tb = $urandom_range(NUM_SLOTS, TIME_MAX);
          end
          2: begin
            tb = near_hot();
            ta = tb + $urandom_range(1, 4);
          end
          default: begin
            ta = near_hot();
            tb = ta + $urandom_range(0, 2000);
          end
        endcase
        send_item(MODE_PERIOD, ta, tb);
      end else if (r < 65) begin
        ta = ($urandom_range(0, 2) != 0) ? near_hot() : $urandom_range(0, TIME_MAX);
        send_item(MODE_SLOT, ta, $urandom_range(0, TIME_MAX));
      end else if (r < 75) begin
        send_item(MODE_TOTAL, $urandom_range(0, TIME_MAX), $urandom_range(0, TIME_MAX));
      end else if (r < 95) begin
        send_item(MODE_ADD, $urandom_range(0, TIME_MAX), $urandom_range(0, TIME_MAX));
      end else begin
        send_item(MODE_W'($urandom_range(5, 7)), $urandom_range(0, TIME_MAX),
                  $urandom_range(0, TIME_MAX));
      end
    end
  endtask

  initial begin
    hot_slot[0] = 0;
    hot_slot[1] = 1;
    hot_slot[2] = NUM_SLOTS - 1;
    hot_slot[3] = NUM_SLOTS - 2;
    for (int i = 4; i < 8; i++) hot_slot[i] = $urandom_range(2, NUM_SLOTS - 3);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Collect phase: empty store, edge slots, ignored items.
    send_item(MODE_TOTAL, 0, 0);
    send_item(MODE_SLOT, 0, 0);
    send_item(MODE_PERIOD, 0, 10);
    send_item(MODE_ADD, 0, TIME_MAX);
    send_item(MODE_ADD, NUM_SLOTS - 1, 0);
    send_item(MODE_ADD, NUM_SLOTS - 1, 0);
    send_item(MODE_ADD, NUM_SLOTS, 0);
    send_item(MODE_ADD, TIME_MAX, TIME_MAX);
    send_item(MODE_W'(5), TIME_MAX, TIME_MAX);
    send_item(MODE_W'(6), 0, 0);
    send_item(MODE_W'(7), 12345, 54321);
    send_item(MODE_SLOT, NUM_SLOTS - 1, 0);
    send_item(MODE_SLOT, TIME_MAX, 0);
    send_item(MODE_TOTAL, 0, 0);

    run_collect_random(420);

    // Query phase: full range, clamped end, single slot, empty windows, late add.
    send_item(MODE_BUILD, 0, 0);
    send_item(MODE_PERIOD, 0, NUM_SLOTS - 1);
    send_item(MODE_PERIOD, 0, TIME_MAX);
    send_item(MODE_PERIOD, NUM_SLOTS - 1, NUM_SLOTS - 1);
    send_item(MODE_PERIOD, NUM_SLOTS, TIME_MAX);
    send_item(MODE_PERIOD, 5, 3);
    send_item(MODE_ADD, 7, 0);
    send_item(MODE_BUILD, 0, 0);
    send_item(MODE_PERIOD, 0, 0);
    send_item(MODE_TOTAL, 0, 0);

    run_query_random(300);
    stop_sending();

    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Covers the clearing pass, two builds and the item traffic several times over.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ time_histogram_range_counter.f @@
+incdir+rtl/core
rtl/core/thrc_pkg.sv
rtl/core/thrc_slot_store.sv
rtl/core/thrc_prefix_store.sv
rtl/core/time_histogram_range_counter.sv
rtl/core/thrc_checker.sv
tb/tb_time_histogram_range_counter.sv
